@@ sv/ang_pkg.sv @@
// Shared types, constants and register map of the audio noise gate.
package ang_pkg;

  parameter int SAMPLE_BITS_DEF    = 16;
  parameter int GAIN_FRAC_BITS_DEF = 16;

  parameter int THR_W  = 10;
  parameter int HOLD_W = 15;
  parameter int RAMP_W = 21;

  parameter int APB_ADDR_W = 5;
  parameter int APB_DATA_W = 32;

  parameter logic [THR_W-1:0]  OPEN_THR_RST   = 10'd500;
  parameter logic [THR_W-1:0]  CLOSE_HYST_RST = 10'd410;
  parameter logic [HOLD_W-1:0] HOLD_RST       = 15'd176;
  parameter logic [RAMP_W-1:0] RELEASE_RST    = 21'd44100;
  parameter logic [RAMP_W-1:0] ATTACK_RST     = 21'd0;

  parameter logic [HOLD_W-1:0] QUIET_MAX = {HOLD_W{1'b1}};

  typedef enum logic [2:0] {
    REG_OPEN_THR   = 3'd0,
    REG_CLOSE_HYST = 3'd1,
    REG_HOLD       = 3'd2,
    REG_RELEASE    = 3'd3,
    REG_ATTACK     = 3'd4
  } ang_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MUL_GAIN,
    ST_MUL_SAMPLE,
    ST_OUT
  } ang_state_t;

  typedef struct packed {
    logic [THR_W-1:0]  open_threshold;
    logic [THR_W-1:0]  close_hysteresis;
    logic [HOLD_W-1:0] hold_samples;
    logic [RAMP_W-1:0] release_samples;
    logic [RAMP_W-1:0] attack_samples;
  } ang_cfg_t;

endpackage

@@ sv/ang_in_if.sv @@
// Input stream channel carrying one audio sample per word.
interface ang_in_if #(
  parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

@@ sv/ang_out_if.sv @@
// Output stream channel carrying one gated audio sample per word.
interface ang_out_if #(
  parameter int SAMPLE_BITS = ang_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

@@ sv/ang_regs.sv @@
// APB configuration register bank of the noise gate.
module ang_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ang_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ang_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ang_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output ang_pkg::ang_cfg_t                cfg
);

  ang_pkg::ang_reg_t reg_sel;
  logic              wr_en;

  assign reg_sel = ang_pkg::ang_reg_t'(paddr[ang_pkg::APB_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_threshold   <= ang_pkg::OPEN_THR_RST;
      cfg.close_hysteresis <= ang_pkg::CLOSE_HYST_RST;
      cfg.hold_samples     <= ang_pkg::HOLD_RST;
      cfg.release_samples  <= ang_pkg::RELEASE_RST;
      cfg.attack_samples   <= ang_pkg::ATTACK_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ang_pkg::REG_OPEN_THR: begin
          cfg.open_threshold <= pwdata[ang_pkg::THR_W-1:0];
        end
        ang_pkg::REG_CLOSE_HYST: begin
          cfg.close_hysteresis <= pwdata[ang_pkg::THR_W-1:0];
        end
        ang_pkg::REG_HOLD: begin
          cfg.hold_samples <= pwdata[ang_pkg::HOLD_W-1:0];
        end
        ang_pkg::REG_RELEASE: begin
          cfg.release_samples <= pwdata[ang_pkg::RAMP_W-1:0];
        end
        ang_pkg::REG_ATTACK: begin
          cfg.attack_samples <= pwdata[ang_pkg::RAMP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ang_pkg::REG_OPEN_THR: begin
        prdata = ang_pkg::APB_DATA_W'(cfg.open_threshold);
      end
      ang_pkg::REG_CLOSE_HYST: begin
        prdata = ang_pkg::APB_DATA_W'(cfg.close_hysteresis);
      end
      ang_pkg::REG_HOLD: begin
        prdata = ang_pkg::APB_DATA_W'(cfg.hold_samples);
      end
      ang_pkg::REG_RELEASE: begin
        prdata = ang_pkg::APB_DATA_W'(cfg.release_samples);
      end
      ang_pkg::REG_ATTACK: begin
        prdata = ang_pkg::APB_DATA_W'(cfg.attack_samples);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

@@ sv/ang_div.sv @@
// Serial restoring divider producing one ramp gain bit per cycle.
module ang_div #(
  parameter int GAIN_FRAC_BITS = ang_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ang_pkg::RAMP_W-1:0]       num,
  input  logic [ang_pkg::RAMP_W-1:0]       den,
  output logic                             done,
  output logic [GAIN_FRAC_BITS:0]          quot
);

  localparam int GW    = GAIN_FRAC_BITS + 1;
  localparam int REM_W = ang_pkg::RAMP_W + 1;
  localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [REM_W-1:0]           rem;
  logic [ang_pkg::RAMP_W-1:0] den_r;
  logic [REM_W-1:0]           rem_sh;
  logic                       ge;
  logic                       last;

  // The numerator never exceeds the divisor, so the first step forms the
  // integer bit without a shift and each later step yields a fraction bit.
  assign rem_sh = (cnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
  assign ge     = rem_sh >= REM_W'(den_r);
  assign last   = cnt == CNT_W'(GAIN_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= REM_W'(num);
      den_r <= den;
      cnt   <= '0;
      quot  <= '0;
    end else if (busy) begin
      rem  <= ge ? (rem_sh - REM_W'(den_r)) : rem_sh;
      quot <= {quot[GW-2:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end
  end

endmodule

@@ sv/ang_seq.sv @@
// Sequencer, gate state and shared multiplier of the noise gate.
module ang_seq #(
  parameter int SAMPLE_BITS    = ang_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ang_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ang_pkg::ang_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        sample_out,
  output logic                          div_start,
  output logic [ang_pkg::RAMP_W-1:0]    div_num,
  output logic [ang_pkg::RAMP_W-1:0]    div_den,
  input  logic                          div_done,
  input  logic [GAIN_FRAC_BITS:0]       div_quot
);

  localparam int GW    = GAIN_FRAC_BITS + 1;
  localparam int MW    = (SAMPLE_BITS > GW) ? SAMPLE_BITS : GW;
  localparam int PW    = MW + GW;
  localparam int CMP_W = (SAMPLE_BITS > ang_pkg::THR_W) ? SAMPLE_BITS : ang_pkg::THR_W;
  localparam int RW    = ang_pkg::RAMP_W;
  localparam int HW    = ang_pkg::HOLD_W;
  localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  ang_pkg::ang_state_t state, state_next;

  logic [HW-1:0]          quiet_count;
  logic [RW-1:0]          fade_count;
  logic [RW-1:0]          rise_count;
  logic [GW-1:0]          fade_gain;
  logic [GW-1:0]          rise_gain;
  logic                   armed;
  logic                   div_to_fade;

  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [GW-1:0]          gain;
  logic [SAMPLE_BITS-1:0] mres;

  logic                   in_neg;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic                   below_hyst;
  logic                   below_open;
  logic                   quiet;
  logic [HW-1:0]          qc_inc;
  logic                   hold_met;
  logic                   fade_step;
  logic                   rise_step;
  logic                   need_div;
  logic                   out_load;
  logic [MW-1:0]          mul_a;
  logic [GW-1:0]          mul_b;
  logic [PW-1:0]          prod;

  assign in_neg = sample_in[SAMPLE_BITS-1];
  assign in_mag = in_neg ? SAMPLE_BITS'(~sample_in + SAMPLE_BITS'(1)) : sample_in;

  assign below_hyst = CMP_W'(mag) < CMP_W'(cfg.close_hysteresis);
  assign below_open = CMP_W'(mag) < CMP_W'(cfg.open_threshold);
  assign quiet      = armed ? below_hyst : below_open;
  assign qc_inc     = (quiet_count == ang_pkg::QUIET_MAX) ? quiet_count
                                                           : quiet_count + HW'(1);
  assign hold_met   = qc_inc >= cfg.hold_samples;
  assign fade_step  = (cfg.release_samples != '0) && (fade_count < cfg.release_samples);
  assign rise_step  = (cfg.attack_samples != '0) && (rise_count < cfg.attack_samples);
  assign need_div   = quiet ? (hold_met && fade_step) : rise_step;
  assign div_num    = quiet ? (cfg.release_samples - fade_count - RW'(1))
                            : (rise_count + RW'(1));
  assign div_den    = quiet ? cfg.release_samples : cfg.attack_samples;

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ang_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ang_pkg::ST_DECIDE;
        end
      end
      ang_pkg::ST_DECIDE: begin
        state_next = need_div ? ang_pkg::ST_DIV : ang_pkg::ST_MUL_GAIN;
      end
      ang_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ang_pkg::ST_MUL_GAIN;
        end
      end
      ang_pkg::ST_MUL_GAIN: begin
        state_next = ang_pkg::ST_MUL_SAMPLE;
      end
      ang_pkg::ST_MUL_SAMPLE: begin
        state_next = ang_pkg::ST_OUT;
      end
      ang_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ang_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ang_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = MW'(rise_gain);
    mul_b     = fade_gain;
    unique case (state)
      ang_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ang_pkg::ST_DECIDE: begin
        div_start = need_div;
      end
      ang_pkg::ST_MUL_SAMPLE: begin
        mul_a = MW'(mag);
        mul_b = gain;
      end
      ang_pkg::ST_OUT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ang_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_count <= '0;
      fade_count  <= '0;
      rise_count  <= '0;
      fade_gain   <= UNITY;
      rise_gain   <= UNITY;
      armed       <= 1'b0;
    end else begin
      unique case (state)
        ang_pkg::ST_DECIDE: begin
          if (quiet) begin
            quiet_count <= qc_inc;
            if (hold_met) begin
              if (below_hyst) begin
                rise_count <= '0;
                rise_gain  <= UNITY;
                armed      <= 1'b0;
              end
              if (fade_step) begin
                fade_count <= fade_count + RW'(1);
              end else if (cfg.release_samples == '0) begin
                fade_gain <= '0;
              end
            end
          end else begin
            quiet_count <= '0;
            fade_count  <= '0;
            fade_gain   <= UNITY;
            armed       <= 1'b1;
            if (rise_step) begin
              rise_count <= rise_count + RW'(1);
            end else begin
              rise_gain <= UNITY;
            end
          end
        end
        ang_pkg::ST_DIV: begin
          if (div_done) begin
            if (div_to_fade) begin
              fade_gain <= div_quot;
            end else begin
              rise_gain <= div_quot;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      neg <= in_neg;
      mag <= in_mag;
    end
    if (state == ang_pkg::ST_DECIDE) begin
      div_to_fade <= quiet;
    end
    if (state == ang_pkg::ST_MUL_GAIN) begin
      gain <= prod[GAIN_FRAC_BITS +: GW];
    end
    if (state == ang_pkg::ST_MUL_SAMPLE) begin
      mres <= prod[GAIN_FRAC_BITS +: SAMPLE_BITS];
    end
    if (out_load) begin
      sample_out <= neg ? SAMPLE_BITS'(~mres + SAMPLE_BITS'(1)) : mres;
    end
  end

endmodule

@@ sv/audio_noise_gate.sv @@
// Top level of the noise gate: register bank, sequencer and ramp divider.
// An accepted word passes through the decide, gain multiply, sample multiply and output
// states, with a divide state after decide when a ramp step divides for a gain.
// A new word is taken only after the last one has been loaded for output, and waits
// on the serial divider, which yields one gain bit per cycle, and on a waiting output word.
// Synchronous reset restores the register defaults and opens the gate at unity.
module audio_noise_gate #(
  parameter int SAMPLE_BITS    = ang_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ang_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ang_in_if.sink                         din,
  ang_out_if.source                      dout,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ang_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ang_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ang_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  ang_pkg::ang_cfg_t           cfg;
  logic                        div_start;
  logic [ang_pkg::RAMP_W-1:0]  div_num;
  logic [ang_pkg::RAMP_W-1:0]  div_den;
  logic                        div_done;
  logic [GAIN_FRAC_BITS:0]     div_quot;
  logic [SAMPLE_BITS-1:0]      sample_out;

  assign dout.sample_out = sample_out;

  ang_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ang_seq #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .sample_in  (din.sample_in),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .sample_out (sample_out),
    .div_start  (div_start),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_done   (div_done),
    .div_quot   (div_quot)
  );

  ang_div #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

@@ sv/ang_chk.sv @@
// Port-level checker of the noise gate and its bind to the top level.
module ang_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'((in_valid && in_ready) ? 1 : 0)
                         - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while a word is still in work");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> pending != 2'd0)
    else $error("output word without a matching input word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two words held inside the gate");

endmodule

bind audio_noise_gate ang_chk u_ang_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready)
);
